FILE: sv/icd_pkg.sv
// shared types and constants for the int8 cosine distance block
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package icd_pkg;

    localparam int MAX_DIMS = 4096;

    localparam int ELEM_W  = 8;
    localparam int DOT_W   = 28;
    localparam int NORM_W  = 27;
    localparam int MAG_W   = 27;
    localparam int COUNT_W = $clog2(MAX_DIMS + 2);
    localparam int DIST_W  = 17;

    localparam int PROD_W  = 2 * NORM_W;
    localparam int ROOT_W  = NORM_W;
    localparam int SREM_W  = ROOT_W + 1;
    localparam int DREM_W  = ROOT_W + 1;
    localparam int QUO_W   = DIST_W;

    localparam int SQRT_STEPS = PROD_W / 2;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [DIST_W-1:0] ONE_Q = DIST_W'(32768);

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       norm_a;
        logic [NORM_W-1:0]       norm_b;
        logic                    overflow;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SQRT,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

FILE: sv/icd_if.sv
// request channel interfaces: element pairs in, distance results out
// depends on icd_pkg for field widths
`timescale 1ns / 1ps

interface icd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [icd_pkg::ELEM_W-1:0]     a_elem;
    logic signed [icd_pkg::ELEM_W-1:0]     b_elem;
    logic                                  last;

    modport source (output valid, output a_elem, output b_elem, output last, input ready);
    modport sink   (input valid, input a_elem, input b_elem, input last, output ready);
endinterface

interface icd_out_if;
    logic                          valid;
    logic                          ready;
    logic [icd_pkg::DIST_W-1:0]    distance;
    logic                          zero_vector;
    logic                          overflow;

    modport source (output valid, output distance, output zero_vector, output overflow,
                    input ready);
    modport sink   (input valid, input distance, input zero_vector, input overflow,
                    output ready);
endinterface

FILE: sv/icd_front.sv
// front end: accepts element pairs, accumulates dot product and norms
// pushes one job per vector pair into the queue; depends on icd_pkg, icd_if
`timescale 1ns / 1ps

module icd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    icd_in_if.sink           i_in,
    input  icd_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output icd_pkg::t_job    o_job
);

    logic signed [icd_pkg::DOT_W-1:0]  r_dot, n_dot;
    logic [icd_pkg::NORM_W-1:0]        r_na, n_na;
    logic [icd_pkg::NORM_W-1:0]        r_nb, n_nb;
    logic [icd_pkg::COUNT_W-1:0]       r_count, n_count;

    logic signed [2*icd_pkg::ELEM_W-1:0] ab, aa, bb;
    logic                                accept;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && i_in.last;

    assign ab = i_in.a_elem * i_in.b_elem;
    assign aa = i_in.a_elem * i_in.a_elem;
    assign bb = i_in.b_elem * i_in.b_elem;

    always_comb begin
        n_dot   = r_dot;
        n_na    = r_na;
        n_nb    = r_nb;
        n_count = r_count;
        if (r_count < icd_pkg::COUNT_W'(icd_pkg::MAX_DIMS)) begin
            n_dot   = r_dot + icd_pkg::DOT_W'(ab);
            n_na    = r_na + icd_pkg::NORM_W'(aa[2*icd_pkg::ELEM_W-2:0]);
            n_nb    = r_nb + icd_pkg::NORM_W'(bb[2*icd_pkg::ELEM_W-2:0]);
            n_count = r_count + 1'b1;
        end else begin
            n_count = icd_pkg::COUNT_W'(icd_pkg::MAX_DIMS + 1);
        end
    end

    always_comb begin
        o_job.dot      = n_dot;
        o_job.norm_a   = n_na;
        o_job.norm_b   = n_nb;
        o_job.overflow = n_count > icd_pkg::COUNT_W'(icd_pkg::MAX_DIMS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot   <= '0;
            r_na    <= '0;
            r_nb    <= '0;
            r_count <= '0;
        end else if (accept) begin
            if (i_in.last) begin
                r_dot   <= '0;
                r_na    <= '0;
                r_nb    <= '0;
                r_count <= '0;
            end else begin
                r_dot   <= n_dot;
                r_na    <= n_na;
                r_nb    <= n_nb;
                r_count <= n_count;
            end
        end
    end

endmodule

FILE: sv/icd_queue.sv
// two-entry job queue between the accumulating front and the divide back end
// depends on icd_pkg
`timescale 1ns / 1ps

module icd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  icd_pkg::t_job     i_job,
    input  logic              i_pop,
    output icd_pkg::t_job     o_job,
    output icd_pkg::t_q_stat  o_stat
);

    icd_pkg::t_job                  r_mem [icd_pkg::Q_DEPTH];
    logic [icd_pkg::Q_PTR_W-1:0]    r_wp;
    logic [icd_pkg::Q_PTR_W-1:0]    r_rp;
    logic [icd_pkg::Q_CNT_W-1:0]    r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = r_cnt == icd_pkg::Q_CNT_W'(icd_pkg::Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == icd_pkg::Q_PTR_W'(icd_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == icd_pkg::Q_PTR_W'(icd_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/icd_back.sv
// back end: norm product, bit-pair square root, restoring divide, result register
// depends on icd_pkg, icd_if
`timescale 1ns / 1ps

module icd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  icd_pkg::t_job    i_job,
    input  icd_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    icd_out_if.source        o_out
);

    icd_pkg::t_back_state r_state, n_state;

    logic                          r_neg;
    logic [icd_pkg::MAG_W-1:0]     r_mag;
    logic [icd_pkg::NORM_W-1:0]    r_na;
    logic [icd_pkg::NORM_W-1:0]    r_nb;
    logic                          r_ovf;
    logic                          r_zero;
    logic [icd_pkg::PROD_W-1:0]    r_x;
    logic [icd_pkg::SREM_W-1:0]    r_srem;
    logic [icd_pkg::ROOT_W-1:0]    r_root;
    logic [icd_pkg::DREM_W-1:0]    r_drem;
    logic [icd_pkg::QUO_W-1:0]     r_num;
    logic [icd_pkg::QUO_W-1:0]     r_quo;
    logic [icd_pkg::CNT_W-1:0]     r_cnt;

    logic                          r_out_valid;
    logic [icd_pkg::DIST_W-1:0]    r_dist;
    logic                          r_out_zero;
    logic                          r_out_ovf;

    logic                          out_load;
    logic signed [icd_pkg::DOT_W-1:0] neg_dot;
    logic [icd_pkg::MAG_W-1:0]     job_mag;
    logic [icd_pkg::PROD_W-1:0]    prod;
    logic [icd_pkg::SREM_W+1:0]    s_cur, s_trial, s_diff;
    logic                          s_ge;
    logic [icd_pkg::DREM_W:0]      d_cur, d_div, d_diff;
    logic                          d_ge;
    logic [icd_pkg::QUO_W-1:0]     qm;
    logic [icd_pkg::DIST_W-1:0]    dist_val;

    assign neg_dot = -i_job.dot;
    assign job_mag = i_job.dot[icd_pkg::DOT_W-1] ? neg_dot[icd_pkg::MAG_W-1:0]
                                                 : i_job.dot[icd_pkg::MAG_W-1:0];
    assign prod = r_na * r_nb;

    // one result bit per cycle of the root
    assign s_cur   = {r_srem, r_x[icd_pkg::PROD_W-1 -: 2]};
    assign s_trial = {1'b0, icd_pkg::ROOT_W'(r_root), 2'b01};
    assign s_diff  = s_cur - s_trial;
    assign s_ge    = s_cur >= s_trial;

    // one quotient bit per cycle of the divide
    assign d_cur  = {r_drem, r_num[icd_pkg::QUO_W-1]};
    assign d_div  = {2'b00, r_root};
    assign d_diff = d_cur - d_div;
    assign d_ge   = d_cur >= d_div;

    assign qm = (r_quo > icd_pkg::ONE_Q) ? icd_pkg::ONE_Q : r_quo;
    always_comb begin
        if (r_zero) begin
            dist_val = icd_pkg::ONE_Q;
        end else if (r_neg) begin
            dist_val = icd_pkg::ONE_Q + qm;
        end else begin
            dist_val = icd_pkg::ONE_Q - qm;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            icd_pkg::BK_IDLE: begin
                if (!i_q_stat.empty) n_state = icd_pkg::BK_MUL;
            end
            icd_pkg::BK_MUL: begin
                n_state = r_zero ? icd_pkg::BK_DONE : icd_pkg::BK_SQRT;
            end
            icd_pkg::BK_SQRT: begin
                if (r_cnt == '0) n_state = icd_pkg::BK_DIV;
            end
            icd_pkg::BK_DIV: begin
                if (r_cnt == '0) n_state = icd_pkg::BK_DONE;
            end
            icd_pkg::BK_DONE: begin
                if (!r_out_valid || o_out.ready) n_state = icd_pkg::BK_IDLE;
            end
            default: n_state = icd_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            icd_pkg::BK_IDLE: o_pop    = !i_q_stat.empty;
            icd_pkg::BK_DONE: out_load = !r_out_valid || o_out.ready;
            default: begin
                o_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= icd_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            icd_pkg::BK_IDLE: begin
                if (o_pop) begin
                    r_neg  <= i_job.dot[icd_pkg::DOT_W-1];
                    r_mag  <= job_mag;
                    r_na   <= i_job.norm_a;
                    r_nb   <= i_job.norm_b;
                    r_ovf  <= i_job.overflow;
                    r_zero <= (i_job.norm_a == '0) || (i_job.norm_b == '0);
                end
            end
            icd_pkg::BK_MUL: begin
                r_x    <= prod;
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= icd_pkg::CNT_W'(icd_pkg::SQRT_STEPS - 1);
                // numerator is mag * 2^15; its top bits seed the remainder
                r_drem <= icd_pkg::DREM_W'(r_mag[icd_pkg::MAG_W-1:2]);
                r_num  <= {r_mag[1:0], {(icd_pkg::QUO_W-2){1'b0}}};
                r_quo  <= '0;
            end
            icd_pkg::BK_SQRT: begin
                r_srem <= s_ge ? s_diff[icd_pkg::SREM_W-1:0] : s_cur[icd_pkg::SREM_W-1:0];
                r_root <= {r_root[icd_pkg::ROOT_W-2:0], s_ge};
                r_x    <= {r_x[icd_pkg::PROD_W-3:0], 2'b00};
                r_cnt  <= (r_cnt == '0) ? icd_pkg::CNT_W'(icd_pkg::DIV_STEPS - 1)
                                        : r_cnt - 1'b1;
            end
            icd_pkg::BK_DIV: begin
                r_drem <= d_ge ? d_diff[icd_pkg::DREM_W-1:0] : d_cur[icd_pkg::DREM_W-1:0];
                r_num  <= {r_num[icd_pkg::QUO_W-2:0], 1'b0};
                r_quo  <= {r_quo[icd_pkg::QUO_W-2:0], d_ge};
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_dist     <= dist_val;
            r_out_zero <= r_zero;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.distance    = r_dist;
    assign o_out.zero_vector = r_out_zero;
    assign o_out.overflow    = r_out_ovf;

endmodule

FILE: sv/int8_cosine_distance_top.sv
// top level of the int8 cosine distance block: front, job queue, back end
// depends on icd_pkg, icd_if, icd_front, icd_queue, icd_back
//
//   channel  dir  payload                               handshake
//   i_in     in   a_elem[7:0] b_elem[7:0] last          valid / ready
//   o_out    out  distance[16:0] zero_vector overflow   valid / ready
//
// one element pair per cycle while ready is high; the front sums a vector pair by pair
// the back end takes one job at a time; its one-bit-per-cycle root (27 steps)
// and divide (17 steps) units run in turn, and a zero vector skips both
// a two-entry queue holds finished accumulations; ready drops only while it is full
// synchronous active-low reset clears sums, count, queue, back state and output valid
// a stalled output holds its result while the front keeps accumulating until the queue fills
`timescale 1ns / 1ps

module int8_cosine_distance_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    icd_in_if.sink     i_in,
    icd_out_if.source  o_out
);

    logic             q_push;
    logic             q_pop;
    icd_pkg::t_job    push_job;
    icd_pkg::t_job    pop_job;
    icd_pkg::t_q_stat q_stat;

    icd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    icd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (pop_job),
        .o_stat  (q_stat)
    );

    icd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (pop_job),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.zero_vector) |-> (o_out.distance == icd_pkg::ONE_Q))
        else $error("zero vector result with wrong distance");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.distance <= 17'd65536))
        else $error("distance out of range");
`endif

endmodule
